@@ hw/rtl/fbc_pkg.sv @@
// Shared types, constants and round functions of the Feistel block cipher pipeline.
// Used by fbc_round, feistel_block_cipher_rounds and fbc_checker; depends on nothing.
`default_nettype none

package fbc_pkg;

   localparam int unsigned BLOCK_BYTES = 8;
   localparam int unsigned KEY_BYTES   = 4;
   localparam int unsigned ROUNDS      = 16;

   localparam int unsigned HALF_BYTES    = BLOCK_BYTES / 2;
   localparam int unsigned KEY_REG_BYTES = 4;
   localparam int unsigned BLOCK_W       = BLOCK_BYTES * 8;
   localparam int unsigned HALF_W        = HALF_BYTES * 8;
   localparam int unsigned KEY_REG_W     = KEY_REG_BYTES * 8;

   localparam logic [7:0] RF_XOR   = 8'hD5;
   localparam int unsigned RF_SHIFT = 3;

   typedef struct packed {
      logic valid;
      logic action;
   } fbc_ctl_type;

   function automatic logic [HALF_W-1:0] fbc_subkey(input logic [KEY_REG_W-1:0] key,
                                                    input int unsigned rnd);
      logic [HALF_W-1:0] sk;
      int unsigned idx;
      sk = '0;
      for (int unsigned i = 0; i < HALF_BYTES; i++) begin
         idx = (i + rnd) % KEY_BYTES;
         if (idx < KEY_REG_BYTES) begin
            sk[8*i +: 8] = 8'(key >> (8 * idx));
         end
      end
      return sk;
   endfunction

   // the odd last byte, when there is one, passes through
   function automatic logic [BLOCK_W-1:0] fbc_round_fn(input logic [BLOCK_W-1:0] blk,
                                                       input logic [HALF_W-1:0] key);
      logic [BLOCK_W-1:0] res;
      logic [7:0] h;
      logic [7:0] l;
      logic [7:0] k;
      logic [7:0] a;
      logic [7:0] f;
      res = blk;
      for (int unsigned i = 0; i < HALF_BYTES; i++) begin
         l = blk[8*i +: 8];
         h = blk[HALF_W + 8*i +: 8];
         k = key[8*i +: 8];
         a = h ^ (k & h) ^ RF_XOR;
         f = ((a & (k >> RF_SHIFT)) ^ h) | k;
         res[8*i +: 8]          = h;
         res[HALF_W + 8*i +: 8] = l ^ f;
      end
      return res;
   endfunction

   function automatic logic [BLOCK_W-1:0] fbc_swap(input logic [BLOCK_W-1:0] blk);
      logic [BLOCK_W-1:0] res;
      res = blk;
      res[HALF_W-1:0]        = blk[2*HALF_W-1:HALF_W];
      res[2*HALF_W-1:HALF_W] = blk[HALF_W-1:0];
      return res;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/feistel_block_cipher_rounds.sv @@
// Feistel block cipher: one round per pipeline stage, then an output register.
// A block passes through every round stage and then the output register before its result is valid.
// Throughput: one block per cycle; a full stage holds while the one below is stalled.
// Reset clears all valid bits and the master key; round payload registers are not reset.
// Depends on fbc_pkg and fbc_round.
`default_nettype none

module feistel_block_cipher_rounds (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic                         req_action,
   input  wire logic [fbc_pkg::BLOCK_W-1:0]  req_block_in,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [fbc_pkg::BLOCK_W-1:0]       rsp_block_out,
   input  wire logic                         csr_wr_en,
   input  wire logic [fbc_pkg::KEY_REG_W-1:0] csr_wr_data
);
   import fbc_pkg::*;

   logic [KEY_REG_W-1:0] csr_key_ff;
   logic [KEY_REG_W-1:0] csr_key_in;

   fbc_ctl_type          stage_ctl   [ROUNDS+1];
   logic [BLOCK_W-1:0]   stage_block [ROUNDS+1];
   logic                 stage_ready [ROUNDS+1];

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [BLOCK_W-1:0]   rsp_block_ff;
   logic [BLOCK_W-1:0]   rsp_block_in;
   logic                 out_ready;

   assign csr_key_in = csr_wr_en ? csr_wr_data : csr_key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_key_ff <= '0;
      end else begin
         csr_key_ff <= csr_key_in;
      end
   end

   assign stage_ctl[0].valid  = req_valid;
   assign stage_ctl[0].action = req_action;
   assign stage_block[0]      = req_block_in;
   assign req_stall           = !stage_ready[0];

   for (genvar s = 0; s < ROUNDS; s++) begin : g_round
      fbc_round u_round (
         .clock      (clock),
         .reset      (reset),
         .in_ctl     (stage_ctl[s]),
         .in_block   (stage_block[s]),
         .key_enc    (fbc_subkey(csr_key_ff, s)),
         .key_dec    (fbc_subkey(csr_key_ff, ROUNDS - 1 - s)),
         .down_ready (stage_ready[s+1]),
         .up_ready   (stage_ready[s]),
         .out_ctl    (stage_ctl[s+1]),
         .out_block  (stage_block[s+1])
      );
   end

   // final half swap; hold while the result is stalled
   assign out_ready           = !rsp_valid_ff || !rsp_stall;
   assign stage_ready[ROUNDS] = out_ready;

   always_comb begin
      rsp_valid_in = out_ready ? stage_ctl[ROUNDS].valid : rsp_valid_ff;
      rsp_block_in = out_ready ? fbc_swap(stage_block[ROUNDS]) : rsp_block_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_block_ff <= rsp_block_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_block_out = rsp_block_ff;

endmodule

`default_nettype wire

@@ hw/rtl/fbc_round.sv @@
// One Feistel round as a pipeline stage with its own valid bit and stall chain.
// Depends on fbc_pkg for the round function and control struct.
`default_nettype none

module fbc_round (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire fbc_pkg::fbc_ctl_type         in_ctl,
   input  wire logic [fbc_pkg::BLOCK_W-1:0]  in_block,
   input  wire logic [fbc_pkg::HALF_W-1:0]   key_enc,
   input  wire logic [fbc_pkg::HALF_W-1:0]   key_dec,
   input  wire logic                         down_ready,
   output logic                              up_ready,
   output fbc_pkg::fbc_ctl_type              out_ctl,
   output logic [fbc_pkg::BLOCK_W-1:0]       out_block
);
   import fbc_pkg::*;

   fbc_ctl_type        ctl_ff;
   fbc_ctl_type        ctl_in;
   logic [BLOCK_W-1:0] block_ff;
   logic [BLOCK_W-1:0] block_in;

   assign up_ready = !ctl_ff.valid || down_ready;

   always_comb begin
      ctl_in   = up_ready ? in_ctl : ctl_ff;
      block_in = up_ready ? fbc_round_fn(in_block, in_ctl.action ? key_dec : key_enc)
                          : block_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      block_ff <= block_in;
   end

   assign out_ctl   = ctl_ff;
   assign out_block = block_ff;

endmodule

`default_nettype wire

@@ hw/rtl/fbc_checker.sv @@
// Port-level checks of the Feistel block cipher pipeline, bound to the top level.
// Depends on fbc_pkg and feistel_block_cipher_rounds.
`default_nettype none

module fbc_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_stall,
   input wire logic                         req_action,
   input wire logic [fbc_pkg::BLOCK_W-1:0]  req_block_in,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic [fbc_pkg::BLOCK_W-1:0]  rsp_block_out,
   input wire logic                         csr_wr_en
);
   import fbc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_block_out))
      else $error("stalled result transfer changed");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_action) && $stable(req_block_in))
      else $error("stalled input transfer changed");

   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a stalled result");

   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |-> !req_valid && !rsp_valid)
      else $error("key written with a transfer in flight");

   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

endmodule

bind feistel_block_cipher_rounds fbc_checker u_fbc_checker (.*);

`default_nettype wire
